>>> rtl/core/iopt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package iopt_pkg;

   localparam int PAGES       = 4096;
   localparam int PAGE_BITS   = $clog2(PAGES);
   localparam int VPN_BITS    = 20;
   localparam int COUNT_BITS  = 13;
   localparam int QDEPTH      = 2;
   localparam int QPTR_BITS   = $clog2(QDEPTH);

   localparam logic [VPN_BITS:0] PAGES_EXT  = (VPN_BITS + 1)'(PAGES);
   localparam logic [63:0] ENTRY_BASE       = 64'h0060_0000_0000_0E03;
   localparam logic [63:0] ENTRY_AP_RW      = 64'h0000_0000_0000_0040;
   localparam logic [63:0] ENTRY_AP_RO      = 64'h0000_0000_0000_00C0;
   localparam logic [47:0] ADDR_FIELD       = 48'hFFFF_FFFF_F000;
   localparam logic [1:0]  TYPE_PAGE        = 2'b11;

   localparam logic [2:0] ATTR_NORMAL    = 3'd0;
   localparam logic [2:0] ATTR_CACHEABLE = 3'd1;
   localparam logic [2:0] ATTR_DEVICE    = 3'd2;
   localparam logic [2:0] ATTR_UPSTREAM  = 3'd3;

   typedef enum logic [1:0] {
      OP_MAP   = 2'd0,
      OP_UNMAP = 2'd1,
      OP_XLATE = 2'd2,
      OP_RSVD  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_READ,
      CMD_REPLY
   } cmd_kind_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_WRITE,
      BK_READ,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] iova;
      logic [47:0] phys_addr;
      logic [12:0] page_count;
      logic        allow_write;
      logic        is_mmio;
      logic        is_cacheable;
      logic        upstream_hint;
      logic        mark_stale;
   } req_word_type;

   typedef struct packed {
      logic        status;
      logic [47:0] translated_addr;
      logic        fault;
      logic        tlb_flush;
   } rsp_word_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic                    is_map;
      logic                    status;
      logic                    flush;
      logic [PAGE_BITS-1:0]    page;
      logic [COUNT_BITS-1:0]   count;
      logic [63:0]             data;
      logic [11:0]             offs;
   } cmd_type;

   typedef struct packed {
      logic    empty;
      logic    full;
      cmd_type head;
   } queue_status_type;

endpackage

`default_nettype wire

>>> rtl/core/io_page_table_map_translate.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_word  (iopt_pkg::req_word_type)
// rsp_      out        rsp_valid / rsp_ready  rsp_word  (iopt_pkg::rsp_word_type)
// csr_      in         csr_write_en           csr_write_data (stale marker byte)
//
// Map or unmap of N pages occupies the back end while it writes the pages in
// turn through the write port; translate uses a registered memory read; a
// refused, zero-page or unused request goes straight to the response state.
// After reset the leaf store is cleared one entry per cycle over all PAGES
// (4096) with req_ready low. A two-deep command queue holds requests while
// the back end works or the response register waits on rsp_ready.
`timescale 1ns / 1ps
`default_nettype none

module io_page_table_map_translate (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire iopt_pkg::req_word_type req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output iopt_pkg::rsp_word_type      rsp_word,
   input  wire logic                   csr_write_en,
   input  wire logic [7:0]             csr_write_data
);
   import iopt_pkg::*;

   logic             push;
   cmd_type          push_cmd;
   logic             pop;
   logic             back_ready;
   queue_status_type queue;

   iopt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_word       (req_word),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .queue_full     (queue.full),
      .back_ready     (back_ready),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   iopt_cmd_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .queue    (queue)
   );

   iopt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .queue      (queue),
      .pop        (pop),
      .back_ready (back_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

endmodule

`default_nettype wire

>>> rtl/core/iopt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module iopt_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire iopt_pkg::req_word_type req_word,
   input  wire logic                  csr_write_en,
   input  wire logic [7:0]            csr_write_data,
   input  wire logic                  queue_full,
   input  wire logic                  back_ready,
   output logic                       push,
   output iopt_pkg::cmd_type          push_cmd
);
   import iopt_pkg::*;

   logic [7:0]          marker_ff;
   logic [7:0]          marker_in;
   logic [VPN_BITS-1:0] vpn;
   logic [VPN_BITS:0]   room;
   logic                in_store;
   logic                run_ok;
   logic [2:0]          attr;
   logic [63:0]         entry;
   opcode_type          op;

   assign marker_in = csr_write_en ? csr_write_data : marker_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= '0;
      end else begin
         marker_ff <= marker_in;
      end
   end

   assign req_ready = back_ready && !queue_full;
   assign push      = req_valid && req_ready;

   always_comb begin
      op       = opcode_type'(req_word.opcode);
      vpn      = req_word.iova[31:12];
      in_store = {1'b0, vpn} < PAGES_EXT;
      room     = PAGES_EXT - {1'b0, vpn};
      run_ok   = in_store && ({{(VPN_BITS + 1 - COUNT_BITS){1'b0}}, req_word.page_count} <= room);

      if (req_word.is_mmio) begin
         attr = ATTR_DEVICE;
      end else if (req_word.is_cacheable) begin
         attr = ATTR_CACHEABLE;
      end else if (req_word.upstream_hint) begin
         attr = ATTR_UPSTREAM;
      end else begin
         attr = ATTR_NORMAL;
      end
      entry = ENTRY_BASE | (req_word.allow_write ? ENTRY_AP_RW : ENTRY_AP_RO)
            | {59'd0, attr, 2'b00} | {16'd0, req_word.phys_addr & ADDR_FIELD};

      push_cmd.kind   = CMD_REPLY;
      push_cmd.is_map = 1'b0;
      push_cmd.status = 1'b0;
      push_cmd.flush  = 1'b0;
      push_cmd.page   = vpn[PAGE_BITS-1:0];
      push_cmd.count  = req_word.page_count;
      push_cmd.data   = '0;
      push_cmd.offs   = req_word.iova[11:0];

      case (op)
         OP_MAP: begin
            push_cmd.is_map = 1'b1;
            push_cmd.data   = entry;
            if (!run_ok) begin
               push_cmd.status = 1'b1;
            end else if (req_word.page_count != '0) begin
               push_cmd.kind = CMD_WRITE;
            end
         end
         OP_UNMAP: begin
            push_cmd.data = req_word.mark_stale ? {8{marker_ff}} : 64'd0;
            if (!run_ok) begin
               push_cmd.status = 1'b1;
            end else begin
               push_cmd.flush = !req_word.mark_stale;
               if (req_word.page_count != '0) begin
                  push_cmd.kind = CMD_WRITE;
               end
            end
         end
         OP_XLATE: begin
            if (!in_store) begin
               push_cmd.status = 1'b1;
            end else begin
               push_cmd.kind = CMD_READ;
            end
         end
         default: begin
            push_cmd.kind = CMD_REPLY;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/iopt_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module iopt_cmd_fifo (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire iopt_pkg::cmd_type        push_cmd,
   input  wire logic                    pop,
   output iopt_pkg::queue_status_type   queue
);
   import iopt_pkg::*;

   cmd_type              entry_ff [QDEPTH];
   logic [QPTR_BITS-1:0] wptr_ff;
   logic [QPTR_BITS-1:0] wptr_in;
   logic [QPTR_BITS-1:0] rptr_ff;
   logic [QPTR_BITS-1:0] rptr_in;
   logic [QPTR_BITS:0]   fill_ff;
   logic [QPTR_BITS:0]   fill_in;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      if (push) begin
         wptr_in = (wptr_ff == QPTR_BITS'(QDEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == QPTR_BITS'(QDEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_cmd;
      end
   end

   assign queue.empty = (fill_ff == '0);
   assign queue.full  = (fill_ff == (QPTR_BITS + 1)'(QDEPTH));
   assign queue.head  = entry_ff[rptr_ff];

endmodule

`default_nettype wire

>>> rtl/core/iopt_back.sv
`timescale 1ns / 1ps
`default_nettype none

module iopt_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire iopt_pkg::queue_status_type queue,
   output logic                           pop,
   output logic                           back_ready,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output iopt_pkg::rsp_word_type         rsp_word
);
   import iopt_pkg::*;

   logic [63:0]           leaf_mem [PAGES];
   logic [63:0]           rd_data_ff;

   back_state_type        state_ff;
   back_state_type        state_in;
   logic [PAGE_BITS-1:0]  clr_ff;
   logic [PAGE_BITS-1:0]  clr_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_word_type          rsp_ff;
   rsp_word_type          rsp_in;

   logic [PAGE_BITS-1:0]  page_ff;
   logic [PAGE_BITS-1:0]  page_in;
   logic [COUNT_BITS-1:0] left_ff;
   logic [COUNT_BITS-1:0] left_in;
   logic [63:0]           data_ff;
   logic [63:0]           data_in;
   logic                  map_ff;
   logic                  map_in;
   logic [11:0]           offs_ff;
   logic [11:0]           offs_in;
   rsp_word_type          res_ff;
   rsp_word_type          res_in;

   logic                  mem_we;
   logic [PAGE_BITS-1:0]  mem_addr;
   logic [63:0]           mem_wdata;
   logic                  mem_re;
   logic                  slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign back_ready = (state_ff != BK_CLEAR);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      page_in      = page_ff;
      left_in      = left_ff;
      data_in      = data_ff;
      map_in       = map_ff;
      offs_in      = offs_ff;
      res_in       = res_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = page_ff;
      mem_wdata    = data_ff;
      mem_re       = 1'b0;

      case (state_ff)
         BK_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == PAGE_BITS'(PAGES - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!queue.empty) begin
               pop                    = 1'b1;
               page_in                = queue.head.page;
               left_in                = queue.head.count;
               data_in                = queue.head.data;
               map_in                 = queue.head.is_map;
               offs_in                = queue.head.offs;
               res_in.status          = queue.head.status;
               res_in.translated_addr = '0;
               res_in.fault           = 1'b0;
               res_in.tlb_flush       = queue.head.flush;
               case (queue.head.kind)
                  CMD_WRITE: state_in = BK_WRITE;
                  CMD_READ: begin
                     mem_re   = 1'b1;
                     mem_addr = queue.head.page;
                     state_in = BK_READ;
                  end
                  default:   state_in = BK_DONE;
               endcase
            end
         end
         BK_WRITE: begin
            mem_we  = 1'b1;
            page_in = page_ff + 1'b1;
            left_in = left_ff - 1'b1;
            if (map_ff) begin
               data_in[47:12] = data_ff[47:12] + 1'b1;
            end
            if (left_ff == COUNT_BITS'(1)) begin
               state_in = BK_DONE;
            end
         end
         BK_READ: begin
            if (rd_data_ff[1:0] != TYPE_PAGE) begin
               res_in.fault = 1'b1;
            end else begin
               res_in.translated_addr = {rd_data_ff[47:12], offs_ff};
            end
            state_in = BK_DONE;
         end
         BK_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      page_ff <= page_in;
      left_ff <= left_in;
      data_ff <= data_in;
      map_ff  <= map_in;
      offs_ff <= offs_in;
      res_ff  <= res_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         leaf_mem[mem_addr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= leaf_mem[mem_addr];
      end
   end

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int STORE_PAGES  = iopt_pkg::PAGES;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = 20;

   localparam logic [63:0] PTE_XN        = 64'h3 << 53;
   localparam logic [63:0] PTE_NG        = 64'h1 << 11;
   localparam logic [63:0] PTE_AF        = 64'h1 << 10;
   localparam logic [63:0] PTE_SH_OUTER  = 64'h2 << 8;
   localparam logic [63:0] PTE_AP_RO     = 64'h3 << 6;
   localparam logic [63:0] PTE_AP_RW     = 64'h1 << 6;
   localparam logic [1:0]  PTE_TYPE_PAGE = 2'b11;
   localparam logic [63:0] PTE_FIXED     = PTE_XN | PTE_NG | PTE_AF | PTE_SH_OUTER
                                           | 64'(PTE_TYPE_PAGE);
   localparam logic [47:0] PA_PAGE_MASK  = 48'hFFFF_FFFF_F000;
   localparam logic [47:0] PA_PAGE_STEP  = 48'h1000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   iopt_pkg::req_word_type req_word;
   logic                  rsp_valid;
   logic                  rsp_ready;
   iopt_pkg::rsp_word_type rsp_word;
   logic                  csr_write_en;
   logic [7:0]            csr_write_data;

   logic [63:0]            leaf_model [STORE_PAGES];
   logic [7:0]             marker_model = 8'h00;
   iopt_pkg::rsp_word_type pending_rsp_q [$];
   iopt_pkg::rsp_word_type oldest_rsp;

   bit quiet       = 1'b0;
   int hold_cycles = 0;
   int cycles      = 0;
   int mismatches  = 0;
   int op_count [4] = '{0, 0, 0, 0};
   int refused_seen  = 0;
   int faults_seen   = 0;
   int flushes_seen  = 0;
   int hits_seen     = 0;
   int marker_writes = 0;

   io_page_table_map_translate dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycles,
                  pending_rsp_q.size());
         $display("testbench: FAIL");
         $finish;
      end
   end

   // page table update and expected response for one accepted request
   function automatic iopt_pkg::rsp_word_type apply_request(input iopt_pkg::req_word_type w);
      iopt_pkg::rsp_word_type r;
      int          first;
      int          cnt;
      logic [2:0]  attr;
      logic [63:0] pte;
      logic [47:0] pa;
      r = '0;
      first = int'(w.iova[31:12]);
      cnt = int'(w.page_count);
      case (w.opcode)
         iopt_pkg::OP_MAP, iopt_pkg::OP_UNMAP: begin
            if (first >= STORE_PAGES || cnt > STORE_PAGES - first) begin
               r.status = 1'b1;
            end else if (w.opcode == iopt_pkg::OP_MAP) begin
               if (w.is_mmio)
                  attr = iopt_pkg::ATTR_DEVICE;
               else if (w.is_cacheable)
                  attr = iopt_pkg::ATTR_CACHEABLE;
               else if (w.upstream_hint)
                  attr = iopt_pkg::ATTR_UPSTREAM;
               else
                  attr = iopt_pkg::ATTR_NORMAL;
               pte = PTE_FIXED | (64'(attr) << 2) | (w.allow_write ? PTE_AP_RW : PTE_AP_RO);
               pa = w.phys_addr & PA_PAGE_MASK;
               for (int i = 0; i < cnt; i++) begin
                  leaf_model[first + i] = pte | {16'h0, pa};
                  pa = pa + PA_PAGE_STEP;
               end
            end else begin
               pte = w.mark_stale ? {8{marker_model}} : 64'h0;
               r.tlb_flush = !w.mark_stale;
               for (int i = 0; i < cnt; i++)
                  leaf_model[first + i] = pte;
            end
         end
         iopt_pkg::OP_XLATE: begin
            if (first >= STORE_PAGES) begin
               r.status = 1'b1;
            end else begin
               pte = leaf_model[first];
               if (pte[1:0] != PTE_TYPE_PAGE)
                  r.fault = 1'b1;
               else
                  r.translated_addr = {pte[47:12], w.iova[11:0]};
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic int pick_page();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(0, 63);
      if (r < 85)
         return $urandom_range(0, STORE_PAGES - 1);
      return $urandom_range(STORE_PAGES - 32, STORE_PAGES - 1);
   endfunction

   function automatic logic [12:0] pick_count(input int first);
      int r;
      int avail;
      int n;
      r = $urandom_range(0, 99);
      avail = STORE_PAGES - first;
      if (r < 3)
         return 13'($urandom_range(0, avail));
      if (r < 8)
         return 13'($urandom_range(0, 8191));
      n = $urandom_range(0, 8);
      return 13'((n < avail) ? n : avail);
   endfunction

   function automatic iopt_pkg::req_word_type make_req(input logic [1:0] op,
                                                       input logic [19:0] page,
                                                       input logic [12:0] count);
      iopt_pkg::req_word_type w;
      w.opcode = op;
      w.iova = {page, 12'($urandom)};
      w.phys_addr = {16'($urandom), 32'($urandom)};
      w.page_count = count;
      {w.allow_write, w.is_mmio, w.is_cacheable, w.upstream_hint, w.mark_stale} =
         5'($urandom);
      return w;
   endfunction

   task automatic send_req(input iopt_pkg::req_word_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word = w;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_rsp_q.push_back(apply_request(w));
      op_count[w.opcode]++;
      @(negedge clock);
   endtask

   task automatic set_marker(input logic [7:0] value);
      req_valid = 1'b0;
      while (pending_rsp_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_write_en = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_en = 1'b0;
      marker_model = value;
      marker_writes++;
   endtask

   task automatic report_mismatch(input string what, input iopt_pkg::rsp_word_type exp_w,
                                  input iopt_pkg::rsp_word_type got_w);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t %s: exp status=%0b addr=%h fault=%0b flush=%0b, got status=%0b addr=%h fault=%0b flush=%0b",
                  $realtime, what, exp_w.status, exp_w.translated_addr, exp_w.fault,
                  exp_w.tlb_flush, got_w.status, got_w.translated_addr, got_w.fault,
                  got_w.tlb_flush);
   endtask

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("unexpected response", '0, rsp_word);
         end else begin
            oldest_rsp = pending_rsp_q.pop_front();
            if (rsp_word.status !== oldest_rsp.status
                || rsp_word.translated_addr !== oldest_rsp.translated_addr
                || rsp_word.fault !== oldest_rsp.fault
                || rsp_word.tlb_flush !== oldest_rsp.tlb_flush)
               report_mismatch("response mismatch", oldest_rsp, rsp_word);
            refused_seen += oldest_rsp.status;
            faults_seen += oldest_rsp.fault;
            flushes_seen += oldest_rsp.tlb_flush;
            if (oldest_rsp.translated_addr != '0)
               hits_seen++;
         end
      end
   end

   initial begin
      int stall;
      stall = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready = 1'b0;
            hold_cycles--;
         end else if (stall > 0) begin
            rsp_ready = 1'b0;
            stall--;
         end else begin
            rsp_ready = 1'b1;
            stall = pick_gap();
         end
      end
   end

   task automatic test_directed_cases();
      iopt_pkg::req_word_type w;
      w = make_req(iopt_pkg::OP_XLATE, 20'd0, 13'd0);
      send_req(w);
      w = make_req(iopt_pkg::OP_MAP, 20'd0, 13'd1);
      w.phys_addr = '1;
      {w.allow_write, w.is_mmio, w.is_cacheable, w.upstream_hint} = 4'b1111;
      send_req(w);
      w = make_req(iopt_pkg::OP_XLATE, 20'd0, 13'd0);
      w.iova[11:0] = 12'hFFF;
      send_req(w);
      w = make_req(iopt_pkg::OP_MAP, 20'd1, 13'd1);
      w.phys_addr = '0;
      {w.allow_write, w.is_mmio, w.is_cacheable, w.upstream_hint} = 4'b0011;
      send_req(w);
      w = make_req(iopt_pkg::OP_XLATE, 20'd1, 13'd0);
      w.iova[11:0] = 12'h000;
      send_req(w);
      w = make_req(iopt_pkg::OP_MAP, 20'd2, 13'd1);
      {w.is_mmio, w.is_cacheable, w.upstream_hint} = 3'b001;
      send_req(w);
      w = make_req(iopt_pkg::OP_MAP, 20'd3, 13'd1);
      {w.is_mmio, w.is_cacheable, w.upstream_hint} = 3'b000;
      send_req(w);
      // output address wraps past the top of the physical space
      w = make_req(iopt_pkg::OP_MAP, 20'd10, 13'd3);
      w.phys_addr = 48'hFFFF_FFFF_F123;
      send_req(w);
      for (int p = 10; p <= 11; p++)
         send_req(make_req(iopt_pkg::OP_XLATE, 20'(p), 13'd0));
      send_req(make_req(iopt_pkg::OP_MAP, 20'(STORE_PAGES - 1), 13'd1));
      w = make_req(iopt_pkg::OP_XLATE, 20'(STORE_PAGES - 1), 13'd0);
      w.iova[11:0] = 12'hFFF;
      send_req(w);
      // refused: run past the end, first page beyond, translate beyond, huge count
      send_req(make_req(iopt_pkg::OP_MAP, 20'(STORE_PAGES - 1), 13'd2));
      send_req(make_req(iopt_pkg::OP_UNMAP, 20'(STORE_PAGES), 13'd0));
      w = make_req(iopt_pkg::OP_XLATE, 20'hFFFFF, 13'd0);
      w.iova = '1;
      send_req(w);
      send_req(make_req(iopt_pkg::OP_UNMAP, 20'd0, 13'h1FFF));
      send_req(make_req(iopt_pkg::OP_MAP, 20'd5, 13'd0));
      send_req(make_req(iopt_pkg::OP_XLATE, 20'd5, 13'd0));
      w = make_req(iopt_pkg::OP_UNMAP, 20'd0, 13'd0);
      w.mark_stale = 1'b0;
      send_req(w);
      w = make_req(iopt_pkg::OP_UNMAP, 20'd10, 13'd2);
      w.mark_stale = 1'b1;
      send_req(w);
      send_req(make_req(iopt_pkg::OP_XLATE, 20'd10, 13'd0));
      send_req(make_req(iopt_pkg::OP_RSVD, 20'($urandom), 13'($urandom)));
      send_req(make_req(iopt_pkg::OP_MAP, 20'd0, 13'(STORE_PAGES)));
      send_req(make_req(iopt_pkg::OP_XLATE, 20'd4000, 13'd0));
      w = make_req(iopt_pkg::OP_UNMAP, 20'd0, 13'(STORE_PAGES));
      w.mark_stale = 1'b0;
      send_req(w);
   endtask

   task automatic test_stale_marker();
      logic [7:0] marker_set [7] = '{8'hFF, 8'h00, 8'h03, 8'hA5, 8'h5A, 8'h7F, 8'h80};
      iopt_pkg::req_word_type w;
      for (int k = 0; k < 7; k++) begin
         set_marker(marker_set[k]);
         w = make_req(iopt_pkg::OP_UNMAP, 20'(100 + 4 * k), 13'd2);
         w.mark_stale = 1'b1;
         send_req(w);
         send_req(make_req(iopt_pkg::OP_XLATE, 20'(100 + 4 * k), 13'd0));
         send_req(make_req(iopt_pkg::OP_XLATE, 20'(101 + 4 * k), 13'd0));
      end
   endtask

   task automatic test_rsp_backpressure();
      int p;
      quiet = 1'b1;
      hold_cycles = 400;
      for (int i = 0; i < 24; i++) begin
         p = $urandom_range(0, 15);
         if (i % 3 == 0)
            send_req(make_req(iopt_pkg::OP_MAP, 20'(p), 13'd1));
         else
            send_req(make_req(iopt_pkg::OP_XLATE, 20'(p), 13'd0));
      end
      quiet = 1'b0;
   endtask

   task automatic test_random_traffic(input int n);
      iopt_pkg::req_word_type w;
      int r;
      int first;
      logic [12:0] cnt;
      for (int i = 0; i < n; i++) begin
         if (i % 200 == 199)
            set_marker(8'($urandom));
         if (i % 150 == 0)
            quiet = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         first = pick_page();
         cnt = pick_count(first);
         if (r < 35)
            w = make_req(iopt_pkg::OP_MAP, 20'(first), cnt);
         else if (r < 50)
            w = make_req(iopt_pkg::OP_UNMAP, 20'(first), cnt);
         else if (r < 92)
            w = make_req(iopt_pkg::OP_XLATE, 20'(first), cnt);
         else if (r < 95)
            w = make_req(iopt_pkg::OP_RSVD, 20'($urandom), 13'($urandom));
         else
            w = make_req(2'($urandom_range(0, 2)),
                         20'($urandom_range(STORE_PAGES, 20'hFFFFF)), 13'($urandom));
         send_req(w);
      end
      quiet = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      for (int i = 0; i < STORE_PAGES; i++)
         leaf_model[i] = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_stale_marker();
      test_rsp_backpressure();
      test_random_traffic(1400);

      req_valid = 1'b0;
      while (pending_rsp_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d map, %0d unmap, %0d translate, %0d unused-opcode requests",
               op_count[iopt_pkg::OP_MAP], op_count[iopt_pkg::OP_UNMAP],
               op_count[iopt_pkg::OP_XLATE], op_count[iopt_pkg::OP_RSVD]);
      $display("%0d refused, %0d faults, %0d hits, %0d flushes, %0d marker writes, %0d mismatches",
               refused_seen, faults_seen, hits_seen, flushes_seen, marker_writes, mismatches);
      if (mismatches == 0 && pending_rsp_q.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/iopt_pkg.sv
rtl/core/iopt_front.sv
rtl/core/iopt_cmd_fifo.sv
rtl/core/iopt_back.sv
rtl/core/io_page_table_map_translate.sv
sim/testbench.sv
